### design/hfcfc_pkg.sv
// ----------------------------------------------------------------------------
// hfcfc_pkg: shared constants and helpers for the cell fill classifier
// Fixed-point widths, register map and small min/max helpers.
// ----------------------------------------------------------------------------
package hfcfc_pkg;

  // Fixed-point format of heights and depths
  localparam int unsigned VALUE_BITS    = 32;
  localparam int unsigned FRACTION_BITS = 16;

  // Configuration registers are one bit narrower than a value
  localparam int unsigned REG_BITS  = VALUE_BITS - 1;
  // Fill ratio: Q0.FRACTION_BITS plus one bit for exactly 1.0
  localparam int unsigned FILL_BITS = FRACTION_BITS + 1;

  // Working width for signed sums and compares on doubled values
  localparam int unsigned CALC_BITS = VALUE_BITS + 3;
  // Divisor: max - min + 2 * margin stays below 2^(VALUE_BITS+2)
  localparam int unsigned DEN_BITS  = VALUE_BITS + 2;
  // Partial remainder before the subtract: below twice the divisor
  localparam int unsigned REM_BITS  = VALUE_BITS + 3;

  // APB register map
  localparam int unsigned PDATA_BITS = 32;
  localparam int unsigned ADDR_BITS  = 3;
  localparam logic REG_HEIGHT_MARGIN   = 1'b0;
  localparam logic REG_DRY_DEPTH_LIMIT = 1'b1;

  // Edges from an accepted item to the edge that samples its result strobe
  localparam int unsigned PIPE_DEPTH = FRACTION_BITS + 3;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  function automatic value_t smin(input value_t a, input value_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic value_t smax(input value_t a, input value_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### design/heightfield_cell_fill_classifier_unit.sv
// ----------------------------------------------------------------------------
// heightfield_cell_fill_classifier_unit: heightfield cell fill classifier
// Classifies one grid cell per clock as dry, partly filled or full.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the cell heights and depths with start_i high; the
//   item is taken at that edge. busy_o stays low, so one item enters every
//   clock and items may follow back to back without gaps.
//   Result channel: done_o marks one cycle in which is_active_o and
//   fill_ratio_o hold the result. Results leave in input order.
//   Throughput: one item per cycle. The restoring divider retires one
//   quotient bit per pipeline stage; min/max is registered at the accepting
//   edge, and the bound compares and the output register add one stage each.
//   Configuration: APB port, height_margin at 0x0, dry_depth_limit at 0x4.
//   Write only while the pipeline is empty. pready is always high.
//   Reset: clears the stage valid bits and both registers; no result is
//   presented until a new item enters. The receiver cannot stall, so the
//   pipeline never holds.
// ----------------------------------------------------------------------------
module heightfield_cell_fill_classifier_unit (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // Command channel
  input  logic                                         start_i,
  output logic                                         busy_o,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      center_height_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      height_sw_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      height_nw_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      height_se_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      height_ne_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      center_depth_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      depth_sw_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      depth_nw_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      depth_se_i,
  input  logic signed [hfcfc_pkg::VALUE_BITS-1:0]      depth_ne_i,
  // Result channel
  output logic                                         done_o,
  output logic                                         is_active_o,
  output logic        [hfcfc_pkg::FILL_BITS-1:0]       fill_ratio_o,
  // APB configuration port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic        [hfcfc_pkg::ADDR_BITS-1:0]       paddr,
  input  logic        [hfcfc_pkg::PDATA_BITS-1:0]      pwdata,
  output logic        [hfcfc_pkg::PDATA_BITS-1:0]      prdata,
  output logic                                         pready
);

  localparam int unsigned VB = hfcfc_pkg::VALUE_BITS;
  localparam int unsigned FB = hfcfc_pkg::FRACTION_BITS;
  localparam int unsigned RB = hfcfc_pkg::REG_BITS;
  localparam int unsigned CB = hfcfc_pkg::CALC_BITS;
  localparam int unsigned DB = hfcfc_pkg::DEN_BITS;
  localparam int unsigned MB = hfcfc_pkg::REM_BITS;

  typedef enum logic [1:0] {
    KIND_DRY,
    KIND_FULL,
    KIND_ZERO,
    KIND_DIV
  } kind_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RB-1:0] height_margin_q;
  logic [RB-1:0] dry_depth_limit_q;
  logic          cfg_wr;
  logic          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[hfcfc_pkg::ADDR_BITS-1];

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_margin_q   <= '0;
      dry_depth_limit_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hfcfc_pkg::REG_HEIGHT_MARGIN:   height_margin_q   <= pwdata[RB-1:0];
        hfcfc_pkg::REG_DRY_DEPTH_LIMIT: dry_depth_limit_q <= pwdata[RB-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      hfcfc_pkg::REG_HEIGHT_MARGIN:
        prdata = hfcfc_pkg::PDATA_BITS'(height_margin_q);
      hfcfc_pkg::REG_DRY_DEPTH_LIMIT:
        prdata = hfcfc_pkg::PDATA_BITS'(dry_depth_limit_q);
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: corner min/max
  // --------------------------------------------------------------------------
  logic                  s1_valid_q;
  hfcfc_pkg::value_t     s1_h_q, s1_d_q, s1_min_h_q, s1_max_h_q, s1_max_d_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_h_q     <= center_height_i;
    s1_d_q     <= center_depth_i;
    s1_min_h_q <= hfcfc_pkg::smin(hfcfc_pkg::smin(height_sw_i, height_nw_i),
                                  hfcfc_pkg::smin(height_se_i, height_ne_i));
    s1_max_h_q <= hfcfc_pkg::smax(hfcfc_pkg::smax(height_sw_i, height_nw_i),
                                  hfcfc_pkg::smax(height_se_i, height_ne_i));
    s1_max_d_q <= hfcfc_pkg::smax(hfcfc_pkg::smax(depth_sw_i, depth_nw_i),
                                  hfcfc_pkg::smax(depth_se_i, depth_ne_i));
  end

  // --------------------------------------------------------------------------
  // Stage 2 logic: bound compares on doubled values, divider operands
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] h_x, d_x, min_h_x, max_h_x, max_d_x;
  logic signed [CB-1:0] m2_x, dry2_x, num_x, den_x;
  logic                 is_dry, is_full;
  kind_e                kind_d;

  always_comb begin
    h_x     = CB'(s1_h_q);
    d_x     = CB'(s1_d_q);
    min_h_x = CB'(s1_min_h_q);
    max_h_x = CB'(s1_max_h_q);
    max_d_x = CB'(s1_max_d_q);
    m2_x    = $signed({{(CB-RB-1){1'b0}}, height_margin_q, 1'b0});
    dry2_x  = $signed({{(CB-RB-1){1'b0}}, dry_depth_limit_q, 1'b0});
    num_x   = h_x - min_h_x;
    den_x   = max_h_x - min_h_x + m2_x;
    is_dry  = (h_x <= min_h_x) && ((max_d_x + d_x) < dry2_x);
    is_full = (h_x - max_h_x) > m2_x;
    // Pick the outcome; the divider quotient is used only for a strict fraction
    if (is_dry) begin
      kind_d = KIND_DRY;
    end else if (is_full) begin
      kind_d = KIND_FULL;
    end else if (num_x <= 0) begin
      kind_d = KIND_ZERO;
    end else if (num_x >= den_x) begin
      kind_d = KIND_FULL;
    end else begin
      kind_d = KIND_DIV;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: entry 0 holds operands, entry i holds i quotient bits
  // --------------------------------------------------------------------------
  logic          div_valid_q [0:FB];
  kind_e         div_kind_q  [0:FB];
  logic [MB-1:0] div_rem_q   [0:FB];
  logic [DB-1:0] div_den_q   [0:FB];
  logic [FB-1:0] div_quo_q   [0:FB];

  logic [MB-1:0] step_shift  [0:FB-1];
  logic          step_ge     [0:FB-1];
  logic [MB-1:0] step_rem    [0:FB-1];
  logic [FB-1:0] step_quo    [0:FB-1];

  // One restoring division step per stage
  always_comb begin
    for (int i = 0; i < FB; i++) begin
      step_shift[i] = {div_rem_q[i][MB-2:0], 1'b0};
      step_ge[i]    = step_shift[i] >= MB'(div_den_q[i]);
      step_rem[i]   = step_ge[i] ? (step_shift[i] - MB'(div_den_q[i])) : step_shift[i];
      step_quo[i]   = {div_quo_q[i][FB-2:0], step_ge[i]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= FB; i++) begin
        div_valid_q[i] <= 1'b0;
      end
    end else begin
      div_valid_q[0] <= s1_valid_q;
      for (int i = 1; i <= FB; i++) begin
        div_valid_q[i] <= div_valid_q[i-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    div_kind_q[0] <= kind_d;
    div_rem_q[0]  <= MB'(num_x[DB-1:0]);
    div_den_q[0]  <= den_x[DB-1:0];
    div_quo_q[0]  <= '0;
    for (int i = 1; i <= FB; i++) begin
      div_kind_q[i] <= div_kind_q[i-1];
      div_rem_q[i]  <= step_rem[i-1];
      div_den_q[i]  <= div_den_q[i-1];
      div_quo_q[i]  <= step_quo[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: select fill ratio and register the result
  // --------------------------------------------------------------------------
  logic                 done_q;
  logic                 active_q;
  logic [FB:0]          fill_q;
  logic                 active_d;
  logic [FB:0]          fill_d;

  always_comb begin
    case (div_kind_q[FB])
      KIND_DRY: begin
        active_d = 1'b0;
        fill_d   = '0;
      end
      KIND_FULL: begin
        active_d = 1'b1;
        fill_d   = {1'b1, {FB{1'b0}}};
      end
      KIND_ZERO: begin
        active_d = 1'b1;
        fill_d   = '0;
      end
      default: begin
        active_d = 1'b1;
        fill_d   = {1'b0, div_quo_q[FB]};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid_q[FB];
    end
  end

  always_ff @(posedge clk_i) begin
    active_q <= active_d;
    fill_q   <= fill_d;
  end

  assign done_o       = done_q;
  assign is_active_o  = active_q;
  assign fill_ratio_o = fill_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result appears only for an accepted item, looked up with PIPE_DEPTH
  a_done_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, hfcfc_pkg::PIPE_DEPTH))
    else $error("result strobe without a matching accepted item");

  // A dry cell reports zero fill
  a_dry_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_active_o) |-> (fill_ratio_o == '0))
    else $error("dry cell with nonzero fill");

  // Fill never exceeds one
  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fill_ratio_o <= {1'b1, {FB{1'b0}}}))
    else $error("fill ratio above one");

endmodule
